>>> rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and the CRC-16 byte update for the frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    // Frame layout
    localparam int HEADER_BYTES = 5;
    localparam int CRC_BYTES    = 2;
    localparam logic [7:0] FRAME_OVERHEAD = 8'(HEADER_BYTES + CRC_BYTES);

    // CRC-16/CCITT, MSB first, no reflection, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN     = CFG_INDEX_W'(3);

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0] MIN_LEN_RST     = 8'd7;
    localparam logic [7:0] MAX_LEN_RST     = 8'd255;

    // Event codes
    localparam logic [1:0] EV_HEADER  = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_GOOD    = 2'd2;
    localparam logic [1:0] EV_CRC_ERR = 2'd3;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_TYPE    = 3'd3,
        PH_SEQ     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_CRC_LO  = 3'd7
    } phase_t;

    // Configuration values seen by the parser
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] min_frame_len;
        logic [7:0] max_frame_len;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  frame_type;
        logic [7:0]  sequence_res;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  payload_count;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } res_t;

    // Parser event towards the output register
    typedef struct packed {
        logic valid;
        res_t res;
    } event_t;

    // One byte through the CRC, eight shift steps
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/cfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// Configuration register bank: sync bytes and frame length limits.
// ----------------------------------------------------------------------------
module cfp_cfg_regs
    import cfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first    = cfg_wdata;
                CFG_SYNC_SECOND: cfg_next.sync_second   = cfg_wdata;
                CFG_MIN_LEN:     cfg_next.min_frame_len = cfg_wdata;
                CFG_MAX_LEN:     cfg_next.max_frame_len = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= SYNC_FIRST_RST;
            cfg_reg.sync_second   <= SYNC_SECOND_RST;
            cfg_reg.min_frame_len <= MIN_LEN_RST;
            cfg_reg.max_frame_len <= MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/cfp_parser.sv
// ----------------------------------------------------------------------------
// cfp_parser
// Frame phase machine with running CRC; one byte stepped per accepted beat.
// ----------------------------------------------------------------------------
module cfp_parser
    import cfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output event_t     ev
);

    phase_t      phase_reg,        phase_next;
    logic [7:0]  total_len_reg,    total_len_next;
    logic [7:0]  payload_len_reg,  payload_len_next;
    logic [7:0]  payload_pos_reg,  payload_pos_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  type_reg,         type_next;
    logic [7:0]  seq_reg,          seq_next;
    logic [7:0]  crc_hi_reg,       crc_hi_next;

    logic [15:0] crc_base;
    logic [15:0] crc_step;
    logic [7:0]  len_from_total;
    logic [7:0]  pos_inc;
    logic [15:0] rx_crc;

    // Datapath helpers
    assign crc_base       = (phase_reg == PH_TYPE) ? CRC_INIT : crc_reg;
    assign crc_step       = crc16_update(crc_base, rx_byte);
    assign len_from_total = (total_len_reg > FRAME_OVERHEAD) ?
                            (total_len_reg - FRAME_OVERHEAD) : 8'd0;
    assign pos_inc        = payload_pos_reg + 8'd1;
    assign rx_crc         = {crc_hi_reg, rx_byte};

    // Next state and event
    always_comb
    begin
        phase_next       = phase_reg;
        total_len_next   = total_len_reg;
        payload_len_next = payload_len_reg;
        payload_pos_next = payload_pos_reg;
        crc_next         = crc_reg;
        type_next        = type_reg;
        seq_next         = seq_reg;
        crc_hi_next      = crc_hi_reg;

        ev.valid             = 1'b0;
        ev.res.event_res     = EV_HEADER;
        ev.res.frame_type    = type_reg;
        ev.res.sequence_res  = seq_reg;
        ev.res.data_byte     = 8'd0;
        ev.res.byte_index    = 8'd0;
        ev.res.payload_count = payload_len_reg;
        ev.res.received_crc  = 16'd0;
        ev.res.computed_crc  = 16'd0;

        if (step)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == cfg.sync_first)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    // second sync wins when both sync bytes are equal
                    if (rx_byte == cfg.sync_second)
                        phase_next = PH_LEN;
                    else if (rx_byte != cfg.sync_first)
                        phase_next = PH_SYNC1;
                end
                PH_LEN:
                begin
                    if (rx_byte < cfg.min_frame_len || rx_byte > cfg.max_frame_len)
                        phase_next = PH_SYNC1;
                    else
                    begin
                        total_len_next = rx_byte;
                        phase_next     = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    crc_next   = crc_step;
                    phase_next = PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_next         = rx_byte;
                    crc_next         = crc_step;
                    payload_len_next = len_from_total;
                    payload_pos_next = 8'd0;
                    phase_next       = (len_from_total == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
                    ev.valid             = 1'b1;
                    ev.res.event_res     = EV_HEADER;
                    ev.res.sequence_res  = rx_byte;
                    ev.res.payload_count = len_from_total;
                end
                PH_PAYLOAD:
                begin
                    crc_next         = crc_step;
                    payload_pos_next = pos_inc;
                    if (pos_inc >= payload_len_reg)
                        phase_next = PH_CRC_HI;
                    ev.valid          = 1'b1;
                    ev.res.event_res  = EV_PAYLOAD;
                    ev.res.data_byte  = rx_byte;
                    ev.res.byte_index = payload_pos_reg;
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    phase_next          = PH_SYNC1;
                    ev.valid            = 1'b1;
                    ev.res.event_res    = (rx_crc == crc_reg) ? EV_GOOD : EV_CRC_ERR;
                    ev.res.received_crc = rx_crc;
                    ev.res.computed_crc = crc_reg;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            total_len_reg   <= 8'd0;
            payload_len_reg <= 8'd0;
            payload_pos_reg <= 8'd0;
            crc_reg         <= CRC_INIT;
            type_reg        <= 8'd0;
            seq_reg         <= 8'd0;
            crc_hi_reg      <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            total_len_reg   <= total_len_next;
            payload_len_reg <= payload_len_next;
            payload_pos_reg <= payload_pos_next;
            crc_reg         <= crc_next;
            type_reg        <= type_next;
            seq_reg         <= seq_next;
            crc_hi_reg      <= crc_hi_next;
        end
    end

endmodule

>>> rtl/cfp_out_reg.sv
// ----------------------------------------------------------------------------
// cfp_out_reg
// Result register with valid/ready; accepts a new event while the held one
// is being taken.
// ----------------------------------------------------------------------------
module cfp_out_reg
    import cfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  event_t ev,
    output logic   accept_ok,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign accept_ok = !valid_reg || out_ready;

    always_comb
    begin
        if (ev.valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (ev.valid)
            res_reg <= ev.res;
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/crc_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_parser
// A result beat is registered and valid in the cycle after the byte causing it.
// Throughput: one byte per cycle unless a held result stalls (in_ready low);
// the one-byte CRC update and phase step in the parser set the cycle.
// Reset (rst_n, async low): hunting first sync, CRC 0xFFFF, no result held,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser
    import cfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    // event output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             event_res,
    output logic [7:0]             frame_type,
    output logic [7:0]             sequence_res,
    output logic [7:0]             data_byte,
    output logic [7:0]             byte_index,
    output logic [7:0]             payload_count,
    output logic [15:0]            received_crc,
    output logic [15:0]            computed_crc,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t   cfg;
    event_t ev;
    res_t   res;
    logic   in_fire;

    assign in_fire = in_valid && in_ready;

    cfp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_fire),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .ev      (ev)
    );

    cfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .accept_ok (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Result fields
    assign event_res     = res.event_res;
    assign frame_type    = res.frame_type;
    assign sequence_res  = res.sequence_res;
    assign data_byte     = res.data_byte;
    assign byte_index    = res.byte_index;
    assign payload_count = res.payload_count;
    assign received_crc  = res.received_crc;
    assign computed_crc  = res.computed_crc;

    // Checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

    a_event_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid |-> in_fire)
        else $error("event raised without an accepted byte");

    a_index_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_PAYLOAD) |-> (byte_index < payload_count))
        else $error("payload index beyond payload length");

    a_crc_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_HEADER || event_res == EV_PAYLOAD))
        |-> (received_crc == 16'd0 && computed_crc == 16'd0))
        else $error("CRC fields set before end of frame");

endmodule

>>> tb/frame_event_checker.sv
// ----------------------------------------------------------------------------
// frame_event_checker
// Watches the byte and event channels of the frame parser. It tracks the
// register writes and runs its own deframer and CRC-16 on every accepted
// byte. Each event beat is compared field by field with the oldest event
// still owed.
// ----------------------------------------------------------------------------
module frame_event_checker
    import cfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [1:0]             event_res,
    input  logic [7:0]             frame_type,
    input  logic [7:0]             sequence_res,
    input  logic [7:0]             data_byte,
    input  logic [7:0]             byte_index,
    input  logic [7:0]             payload_count,
    input  logic [15:0]            received_crc,
    input  logic [15:0]            computed_crc,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     events_owed,
    output int                     n_headers,
    output int                     n_payload,
    output int                     n_good,
    output int                     n_crc_err
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow registers and deframer state
    cfg_t        regs;
    phase_t      phase;
    logic [7:0]  total_len;
    logic [7:0]  body_len;
    logic [7:0]  body_pos;
    logic [7:0]  held_type;
    logic [7:0]  held_seq;
    logic [7:0]  crc_hi;
    logic [15:0] crc_acc;
    res_t        owed_events[$];
    int          errors;

    // CRC-16/CCITT, one message bit at a time, MSB first
    function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[k]) ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Advance the deframer by one byte, queue the event it raises
    task automatic predict_frame_event(input logic [7:0] b);
        res_t ev;
        bit   emit;
        ev   = '0;
        emit = 1'b0;
        case (phase)
            PH_SYNC1:
            begin
                if (b == regs.sync_first)
                    phase = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                // second sync wins when both sync values are equal
                if (b == regs.sync_second)
                    phase = PH_LEN;
                else if (b != regs.sync_first)
                    phase = PH_SYNC1;
            end
            PH_LEN:
            begin
                if (b < regs.min_frame_len || b > regs.max_frame_len)
                    phase = PH_SYNC1;
                else
                begin
                    total_len = b;
                    phase     = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                held_type = b;
                crc_acc   = crc16_shift_in(CRC_INIT, b);
                phase     = PH_SEQ;
            end
            PH_SEQ:
            begin
                held_seq = b;
                crc_acc  = crc16_shift_in(crc_acc, b);
                // short lengths saturate to an empty payload
                body_len = (total_len > FRAME_OVERHEAD) ? total_len - FRAME_OVERHEAD : 8'd0;
                body_pos = 8'd0;
                phase    = (body_len == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
                ev.event_res = EV_HEADER;
                emit = 1'b1;
            end
            PH_PAYLOAD:
            begin
                ev.event_res  = EV_PAYLOAD;
                ev.data_byte  = b;
                ev.byte_index = body_pos;
                crc_acc  = crc16_shift_in(crc_acc, b);
                body_pos = body_pos + 8'd1;
                if (body_pos >= body_len)
                    phase = PH_CRC_HI;
                emit = 1'b1;
            end
            PH_CRC_HI:
            begin
                crc_hi = b;
                phase  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                ev.received_crc = {crc_hi, b};
                ev.computed_crc = crc_acc;
                ev.event_res    = (ev.received_crc == crc_acc) ? EV_GOOD : EV_CRC_ERR;
                phase = PH_SYNC1;
                emit  = 1'b1;
            end
        endcase
        if (emit)
        begin
            ev.frame_type    = held_type;
            ev.sequence_res  = held_seq;
            ev.payload_count = body_len;
            owed_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Event beat first, then the byte beat, then any register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs      = {SYNC_FIRST_RST, SYNC_SECOND_RST, MIN_LEN_RST, MAX_LEN_RST};
            phase     = PH_SYNC1;
            total_len = '0;
            body_len  = '0;
            body_pos  = '0;
            held_type = '0;
            held_seq  = '0;
            crc_hi    = '0;
            crc_acc   = CRC_INIT;
            owed_events.delete();
            errors      = 0;
            fail_count  <= 0;
            events_owed <= 0;
            n_headers   <= 0;
            n_payload   <= 0;
            n_good      <= 0;
            n_crc_err   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_events.size() == 0)
                begin
                    $error("event beat %0d arrived with none owed", event_res);
                    errors++;
                end
                else
                begin
                    res_t want;
                    want = owed_events.pop_front();
                    check_field("event_res", 16'(want.event_res), 16'(event_res));
                    check_field("frame_type", 16'(want.frame_type), 16'(frame_type));
                    check_field("sequence_res", 16'(want.sequence_res),
                                16'(sequence_res));
                    check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                    check_field("byte_index", 16'(want.byte_index), 16'(byte_index));
                    check_field("payload_count", 16'(want.payload_count),
                                16'(payload_count));
                    check_field("received_crc", want.received_crc, received_crc);
                    check_field("computed_crc", want.computed_crc, computed_crc);
                    case (want.event_res)
                        EV_HEADER:  n_headers <= n_headers + 1;
                        EV_PAYLOAD: n_payload <= n_payload + 1;
                        EV_GOOD:    n_good    <= n_good + 1;
                        EV_CRC_ERR: n_crc_err <= n_crc_err + 1;
                    endcase
                end
            end

            if (in_valid && in_ready)
                predict_frame_event(rx_byte);

            // unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  regs.sync_first    = cfg_wdata[7:0];
                    CFG_SYNC_SECOND: regs.sync_second   = cfg_wdata[7:0];
                    CFG_MIN_LEN:     regs.min_frame_len = cfg_wdata[7:0];
                    CFG_MAX_LEN:     regs.max_frame_len = cfg_wdata[7:0];
                    default: ;
                endcase
            end

            fail_count  <= errors;
            events_owed <= owed_events.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the CRC checked frame parser. Well-formed frames
// with random content make up most of the stream, mixed with noise, repeated
// sync bytes, rejected lengths and cut-off frames. This runs over several
// register settings and under changing backpressure. The checker beside the
// parser does the prediction and the compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cfp_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 300000;

    // indexes the parser does not decode
    localparam logic [CFG_INDEX_W-1:0] CFG_STRAY_LO = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_STRAY_HI = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             event_res;
    logic [7:0]             frame_type;
    logic [7:0]             sequence_res;
    logic [7:0]             data_byte;
    logic [7:0]             byte_index;
    logic [7:0]             payload_count;
    logic [15:0]            received_crc;
    logic [15:0]            computed_crc;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int  fail_count;
    int  events_owed;
    int  n_headers;
    int  n_payload;
    int  n_good;
    int  n_crc_err;
    int  cycle_count;
    int  bytes_sent;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;

    // what the parser was last told
    logic [7:0] cur_s1;
    logic [7:0] cur_s2;
    logic [7:0] cur_min;
    logic [7:0] cur_max;

    crc_checked_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .frame_type    (frame_type),
        .sequence_res  (sequence_res),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .payload_count (payload_count),
        .received_crc  (received_crc),
        .computed_crc  (computed_crc),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    frame_event_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .frame_type    (frame_type),
        .sequence_res  (sequence_res),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .payload_count (payload_count),
        .received_crc  (received_crc),
        .computed_crc  (computed_crc),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .events_owed   (events_owed),
        .n_headers     (n_headers),
        .n_payload     (n_payload),
        .n_good        (n_good),
        .n_crc_err     (n_crc_err)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Event side: random stalls, plus a long hold on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // CRC over type, sequence and payload, for building frames
    function automatic logic [15:0] frame_crc(input logic [7:0] body[$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (body[i])
        begin
            for (int k = 7; k >= 0; k--)
            begin
                c = {c[14:0], 1'b0} ^ ((c[15] ^ body[i][k]) ? CRC_POLY : 16'h0000);
            end
        end
        return c;
    endfunction

    // Mostly short frames, now and then anything the limits allow
    function automatic logic [7:0] pick_len();
        int lo;
        int hi;
        lo = cur_min;
        hi = cur_max;
        if (lo > hi)
            return cur_min;
        if ($urandom_range(99) < 3)
            return 8'($urandom_range(lo, hi));
        return 8'($urandom_range(lo, (hi - lo > 14) ? lo + 14 : hi));
    endfunction

    // One byte beat; called at a clock edge, returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Stop sending until every owed event has come, then let the parser go idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (events_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] mn, input logic [7:0] mx,
                                input bit stray);
        if (stray)
        begin
            write_reg(CFG_STRAY_LO, 8'($urandom));
            write_reg(CFG_STRAY_HI, 8'($urandom));
        end
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_MIN_LEN, mn);
        write_reg(CFG_MAX_LEN, mx);
        cfg_we  <= 1'b0;
        cur_s1  = s1;
        cur_s2  = s2;
        cur_min = mn;
        cur_max = mx;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                              input logic [7:0] fseq, input bit corrupt_crc);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          n_body;
        n_body = (len > FRAME_OVERHEAD) ? int'(len) - int'(FRAME_OVERHEAD) : 0;
        body.push_back(ftype);
        body.push_back(fseq);
        repeat (n_body) body.push_back(8'($urandom));
        crc = frame_crc(body);
        if (corrupt_crc)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        send_byte(cur_s1);
        send_byte(cur_s2);
        send_byte(len);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Random stream: mostly good frames, the rest broken or junk
    task automatic random_stream(input int budget);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(pick_len(), 8'($urandom), 8'($urandom), $urandom_range(99) < 20);
            else if (pick < 80)
                send_noise($urandom_range(1, 4));
            else if (pick < 88)
            begin
                // repeated first sync keeps the hunt armed
                repeat ($urandom_range(1, 3)) send_byte(cur_s1);
                send_frame(pick_len(), 8'($urandom), 8'($urandom), 1'b0);
            end
            else if (pick < 94)
            begin
                // length outside the limits
                send_byte(cur_s1);
                send_byte(cur_s2);
                if (cur_min > 0)
                    send_byte(8'($urandom_range(0, int'(cur_min) - 1)));
                else if (cur_max < 8'hFF)
                    send_byte(8'($urandom_range(int'(cur_max) + 1, 255)));
                else
                    send_byte(8'($urandom));
            end
            else
            begin
                // frame cut off after its type byte
                send_byte(cur_s1);
                send_byte(cur_s2);
                send_byte(pick_len());
                send_byte(8'($urandom));
                send_noise($urandom_range(1, 3));
            end
        end
    endtask

    initial
    begin
        logic [7:0] r;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        send_idle_pct = 34;
        recv_idle_pct = 58;
        cur_s1        = SYNC_FIRST_RST;
        cur_s2        = SYNC_SECOND_RST;
        cur_min       = MIN_LEN_RST;
        cur_max       = MAX_LEN_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values
        send_byte(cur_s1);
        send_frame(8'd7, 8'h00, 8'hFF, 1'b0);
        send_frame(8'd8, 8'hFF, 8'h00, 1'b1);
        send_byte(cur_s1);
        send_byte(cur_s2);
        send_byte(8'd6);
        random_stream(50);
        settle();

        // Extreme sync values, only the shortest frame allowed
        program_regs(8'h00, 8'hFF, 8'd7, 8'd7, 1'b1);
        random_stream(40);
        settle();

        // Equal sync bytes, lengths under seven accepted
        send_idle_pct = 58;
        recv_idle_pct = 34;
        r = 8'($urandom);
        program_regs(r, r, 8'd0, 8'd12, 1'b0);
        send_frame(8'd0, 8'($urandom), 8'($urandom), 1'b0);
        send_frame(8'd6, 8'($urandom), 8'($urandom), 1'b1);
        random_stream(40);
        settle();

        // Minimum above maximum: nothing gets past the length byte
        program_regs(8'($urandom), 8'($urandom), 8'd200, 8'd100, 1'b1);
        random_stream(20);
        settle();

        // No idling; long event stall while bytes keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        r = 8'($urandom);
        program_regs(r, ~r, 8'd7, 8'd255, 1'b0);
        hold_req = 1'b1;
        send_frame(8'd40, 8'($urandom), 8'($urandom), 1'b0);
        settle();
        random_stream(50);
        settle();

        program_regs(8'hFF, 8'h00, 8'($urandom_range(7, 20)), 8'($urandom_range(20, 40)), 1'b0);
        random_stream(40);
        settle();

        // Longest frame only
        program_regs(8'h55, 8'hAA, 8'd255, 8'd255, 1'b0);
        send_byte(cur_s1);
        send_byte(cur_s2);
        send_byte(8'd254);
        send_frame(8'd255, 8'($urandom), 8'($urandom), 1'b0);
        settle();

        $display("Covered %0d bytes under seven register settings with changing backpressure.",
                 bytes_sent);
        $display("Events seen: %0d headers, %0d payload, %0d good ends, %0d CRC errors.",
                 n_headers, n_payload, n_good, n_crc_err);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
